// ----- rtl/sstf_pkg.sv -----
package sstf_pkg;

  // Default configuration of the block.
  localparam int unsigned DEF_REQ_DEPTH  = 32;
  localparam int unsigned DEF_TRACK_BITS = 16;

  // Fixed widths of the word fields.
  localparam int unsigned TRACK_W = 16;
  localparam int unsigned DIST_W  = 21;
  localparam int unsigned INDEX_W = 5;

  typedef enum logic [0:0] {
    OP_LOAD = 1'b0,
    OP_RUN  = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_EMIT,
    ST_EMPTY
  } state_e;

  typedef struct packed {
    op_e                op;
    logic [TRACK_W-1:0] track_value;
  } req_word_t;

  typedef struct packed {
    logic [TRACK_W-1:0] served_track;
    logic [DIST_W-1:0]  total_distance;
    logic [INDEX_W-1:0] served_index;
    logic               last_of_run;
    logic               empty_run;
    logic               overflow_seen;
  } res_word_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic run;
    logic scan;
    logic commit;
    logic empty;
  } ctrl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic count_zero;
    logic scan_done;
    logic last_pick;
    logic out_free;
  } dp_stat_t;

endpackage

// ----- rtl/sstf_stream_if.sv -----
interface sstf_stream_if #(
  parameter type word_t = logic
);
  logic  valid;
  logic  ready;
  word_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ----- rtl/sstf_ctrl.sv -----
module sstf_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  sstf_pkg::op_e      in_op_i,
  output logic               in_ready_o,
  input  sstf_pkg::dp_stat_t stat_i,
  output sstf_pkg::ctrl_cmd_t cmd_o
);
  import sstf_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    in_ready_o = 1'b0;
    cmd_o      = '0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          case (in_op_i)
            OP_LOAD: begin
              cmd_o.load = 1'b1;
            end
            OP_RUN: begin
              if (stat_i.count_zero) begin
                state_d = ST_EMPTY;
              end else begin
                cmd_o.run = 1'b1;
                state_d   = ST_SCAN;
              end
            end
            default: begin
              state_d = ST_IDLE;
            end
          endcase
        end
      end
      ST_SCAN: begin
        cmd_o.scan = 1'b1;
        if (stat_i.scan_done) begin
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (stat_i.out_free) begin
          cmd_o.commit = 1'b1;
          state_d      = stat_i.last_pick ? ST_IDLE : ST_SCAN;
        end
      end
      ST_EMPTY: begin
        if (stat_i.out_free) begin
          cmd_o.empty = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

// ----- rtl/sstf_datapath.sv -----
module sstf_datapath #(
  parameter int unsigned REQ_DEPTH  = sstf_pkg::DEF_REQ_DEPTH,
  parameter int unsigned TRACK_BITS = sstf_pkg::DEF_TRACK_BITS
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic [sstf_pkg::TRACK_W-1:0]  track_value_i,
  input  sstf_pkg::ctrl_cmd_t           cmd_i,
  output sstf_pkg::dp_stat_t            stat_o,
  sstf_stream_if.source                 res_o
);
  import sstf_pkg::*;

  localparam int unsigned CNT_W = $clog2(REQ_DEPTH + 1);
  localparam int unsigned IDX_W = (REQ_DEPTH > 1) ? $clog2(REQ_DEPTH) : 1;

  logic [TRACK_BITS-1:0] mem_q [REQ_DEPTH];

  logic [CNT_W-1:0]      count_q, count_d;
  logic                  ovf_q, ovf_d;
  logic [REQ_DEPTH-1:0]  visited_q, visited_d;
  logic [TRACK_BITS-1:0] head_q, head_d;
  logic [DIST_W-1:0]     sum_q, sum_d;
  logic [CNT_W-1:0]      pick_q, pick_d;
  logic [CNT_W-1:0]      issue_q, issue_d;
  logic                  rd_vld_q, rd_vld_d;
  logic [CNT_W-1:0]      rd_cnt_q;
  logic [TRACK_BITS-1:0] rd_data_q;
  logic                  best_found_q, best_found_d;
  logic [TRACK_BITS-1:0] best_t_q;
  logic [TRACK_BITS-1:0] best_dist_q;
  logic [IDX_W-1:0]      best_idx_q;
  logic                  res_vld_q, res_vld_d;
  res_word_t             res_q;

  logic [TRACK_BITS-1:0] track_in;
  logic                  store_ok;
  logic                  issue_en;
  logic [TRACK_BITS-1:0] diff;
  logic                  tie_high;
  logic                  better;
  logic                  take;
  logic                  out_free;
  logic                  last_pick;
  logic [DIST_W-1:0]     sum_next;

  assign track_in  = TRACK_BITS'(track_value_i);
  assign store_ok  = (count_q < CNT_W'(REQ_DEPTH));
  assign issue_en  = cmd_i.scan && (issue_q < count_q);
  assign diff      = (rd_data_q >= head_q) ? (rd_data_q - head_q) : (head_q - rd_data_q);
  // The first pick of a run breaks ties upward, every later one downward.
  assign tie_high  = (pick_q == '0);
  assign better    = !best_found_q || (diff < best_dist_q) ||
                     ((diff == best_dist_q) &&
                      (tie_high ? (rd_data_q > best_t_q) : (rd_data_q < best_t_q)));
  assign take      = rd_vld_q && !visited_q[rd_cnt_q[IDX_W-1:0]] && better;
  assign out_free  = !res_vld_q || res_o.ready;
  assign last_pick = (pick_q == count_q - CNT_W'(1));
  assign sum_next  = sum_q + DIST_W'(best_dist_q);

  assign stat_o.count_zero = (count_q == '0);
  assign stat_o.scan_done  = rd_vld_q && (rd_cnt_q == count_q - CNT_W'(1));
  assign stat_o.last_pick  = last_pick;
  assign stat_o.out_free   = out_free;

  assign res_o.valid = res_vld_q;
  assign res_o.data  = res_q;

  always_comb begin
    count_d      = count_q;
    ovf_d        = ovf_q;
    visited_d    = visited_q;
    head_d       = head_q;
    sum_d        = sum_q;
    pick_d       = pick_q;
    issue_d      = issue_q;
    rd_vld_d     = issue_en;
    best_found_d = best_found_q || take;
    res_vld_d    = res_vld_q && !res_o.ready;
    if (cmd_i.load) begin
      if (store_ok) begin
        count_d = count_q + CNT_W'(1);
      end else begin
        ovf_d = 1'b1;
      end
    end
    if (issue_en) begin
      issue_d = issue_q + CNT_W'(1);
    end
    if (cmd_i.run) begin
      head_d       = track_in;
      sum_d        = '0;
      visited_d    = '0;
      pick_d       = '0;
      issue_d      = '0;
      best_found_d = 1'b0;
    end
    if (cmd_i.commit) begin
      res_vld_d                = 1'b1;
      visited_d[best_idx_q]    = 1'b1;
      head_d                   = best_t_q;
      sum_d                    = sum_next;
      pick_d                   = pick_q + CNT_W'(1);
      issue_d                  = '0;
      best_found_d             = 1'b0;
      if (last_pick) begin
        count_d   = '0;
        visited_d = '0;
      end
    end
    if (cmd_i.empty) begin
      res_vld_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q      <= '0;
      ovf_q        <= 1'b0;
      visited_q    <= '0;
      head_q       <= '0;
      sum_q        <= '0;
      pick_q       <= '0;
      issue_q      <= '0;
      rd_vld_q     <= 1'b0;
      best_found_q <= 1'b0;
      res_vld_q    <= 1'b0;
    end else begin
      count_q      <= count_d;
      ovf_q        <= ovf_d;
      visited_q    <= visited_d;
      head_q       <= head_d;
      sum_q        <= sum_d;
      pick_q       <= pick_d;
      issue_q      <= issue_d;
      rd_vld_q     <= rd_vld_d;
      best_found_q <= best_found_d;
      res_vld_q    <= res_vld_d;
    end
  end

  // Request store with a registered read port.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load && store_ok) begin
      mem_q[count_q[IDX_W-1:0]] <= track_in;
    end
    if (issue_en) begin
      rd_data_q <= mem_q[issue_q[IDX_W-1:0]];
    end
  end

  always_ff @(posedge clk_i) begin
    rd_cnt_q <= issue_q;
    if (take) begin
      best_t_q    <= rd_data_q;
      best_dist_q <= diff;
      best_idx_q  <= rd_cnt_q[IDX_W-1:0];
    end
    if (cmd_i.commit) begin
      res_q.served_track   <= TRACK_W'(best_t_q);
      res_q.total_distance <= sum_next;
      res_q.served_index   <= INDEX_W'(pick_q);
      res_q.last_of_run    <= last_pick;
      res_q.empty_run      <= 1'b0;
      res_q.overflow_seen  <= ovf_q;
    end else if (cmd_i.empty) begin
      res_q.served_track   <= '0;
      res_q.total_distance <= '0;
      res_q.served_index   <= '0;
      res_q.last_of_run    <= 1'b0;
      res_q.empty_run      <= 1'b1;
      res_q.overflow_seen  <= ovf_q;
    end
  end

endmodule

// ----- rtl/sstf_disk_scheduler_core.sv -----
// Channel  Dir  Word        Contents
// req_i    in   req_word_t  op (load or run), track_value
// res_o    out  res_word_t  served_track, total_distance, served_index,
//                           last_of_run, empty_run, overflow_seen
//
// A load word is accepted back to back while no run is in progress.
// A run with n stored requests gives n result words; each pick scans the whole
// store through its single registered read port.
// An empty run gives its single word from the empty state once the result register is free.
// Reset clears the count, visited map, head, sum and overflow flag at once.
// A stalled result holds the next pick in the emit state until the word is taken.
module sstf_disk_scheduler_core #(
  parameter int unsigned REQ_DEPTH  = sstf_pkg::DEF_REQ_DEPTH,
  parameter int unsigned TRACK_BITS = sstf_pkg::DEF_TRACK_BITS
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  sstf_stream_if.sink   req_i,
  sstf_stream_if.source res_o
);
  import sstf_pkg::*;

  // Commands and status joining the controller and the datapath.
  ctrl_cmd_t cmd;
  dp_stat_t  stat;
  req_word_t req_word;

  assign req_word = req_i.data;

  // The controller sequences loads, the nearest-request scans and the emits.
  sstf_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (req_i.valid),
    .in_op_i    (req_word.op),
    .in_ready_o (req_i.ready),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  // The datapath holds the request store, the visited map, the running head and
  // distance, the best-candidate registers of a scan and the result register.
  sstf_datapath #(
    .REQ_DEPTH  (REQ_DEPTH),
    .TRACK_BITS (TRACK_BITS)
  ) u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .track_value_i (req_word.track_value),
    .cmd_i         (cmd),
    .stat_o        (stat),
    .res_o         (res_o)
  );

endmodule

// ----- tb/tb_sstf_disk_scheduler_core.sv -----
module tb_sstf_disk_scheduler_core;
  timeunit 1ns;
  timeprecision 1ps;

  import sstf_pkg::*;

  localparam int unsigned STORE_DEPTH = DEF_REQ_DEPTH;

  // Cycles granted after the final expected word before the verdict. The wait
  // scales with a pick over a full store, so this covers any word that
  // still trails behind.
  localparam int unsigned DRAIN_CYCLES = 4 * (STORE_DEPTH + 2);

  logic clk_i;
  logic rst_ni;

  sstf_stream_if #(.word_t(req_word_t)) req_if ();
  sstf_stream_if #(.word_t(res_word_t)) res_if ();

  sstf_disk_scheduler_core i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if),
    .res_o  (res_if)
  );

  // Request words waiting for the driver, and the services the scheduler
  // must still produce, oldest first.
  req_word_t   pending_words[$];
  res_word_t   expected_services[$];
  int unsigned words_queued;
  int unsigned words_accepted;
  int unsigned mismatches;

  // Idle rates in percent for the request side and the result side.
  int unsigned send_idle_pct;
  int unsigned recv_stall_pct;

  // Shadow copy of the scheduler state.
  logic [TRACK_W-1:0] track_store [STORE_DEPTH];
  int unsigned        track_count;
  logic               overflow_latched;

  initial begin
    clk_i = 1'b0;
  end

  always #5 clk_i = ~clk_i;

  // A load only fills the store; a full store drops the word and latches the
  // sticky overflow flag. A run serves every stored track in
  // shortest-seek-first order: the first pick breaks ties toward the higher
  // track, every later pick toward the lower one.
  task automatic apply_request(input req_word_t w);
    logic [STORE_DEPTH-1:0] served_map;
    logic [TRACK_W-1:0]     head;
    logic [TRACK_W-1:0]     cand;
    logic [TRACK_W-1:0]     gap;
    logic [TRACK_W-1:0]     best_gap;
    logic [21:0]            moved;
    int                     pick;
    res_word_t              r;
    if (w.op == OP_LOAD) begin
      if (track_count < STORE_DEPTH) begin
        track_store[track_count] = w.track_value;
        track_count++;
      end else begin
        overflow_latched = 1'b1;
      end
    end else if (track_count == 0) begin
      r = '0;
      r.empty_run = 1'b1;
      r.overflow_seen = overflow_latched;
      expected_services = {expected_services, r};
    end else begin
      served_map = '0;
      head = w.track_value;
      moved = '0;
      best_gap = '0;
      for (int k = 0; k < track_count; k++) begin
        pick = -1;
        for (int i = 0; i < track_count; i++) begin
          if (!served_map[i]) begin
            cand = track_store[i];
            gap = (cand >= head) ? cand - head : head - cand;
            if (pick < 0 || gap < best_gap) begin
              pick = i;
              best_gap = gap;
            end else if (gap == best_gap) begin
              if ((k == 0 && cand > track_store[pick]) ||
                  (k != 0 && cand < track_store[pick])) begin
                pick = i;
              end
            end
          end
        end
        served_map[pick] = 1'b1;
        moved += best_gap;
        head = track_store[pick];
        r.served_track   = head;
        r.total_distance = moved[DIST_W-1:0];
        r.served_index   = k[INDEX_W-1:0];
        r.last_of_run    = (k == track_count - 1);
        r.empty_run      = 1'b0;
        r.overflow_seen  = overflow_latched;
        expected_services = {expected_services, r};
      end
      track_count = 0;
    end
  endtask

  task automatic compare_field(input string field, input int unsigned want,
                               input int unsigned got);
    if (want != got) begin
      $display("%0t: %s expected %0d actual %0d", $realtime, field, want, got);
      mismatches++;
    end
  endtask

  // Driver: a new word is presented only once the current one is taken or
  // none is shown, so valid never drops before its handshake.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_if.valid <= 1'b0;
      req_if.data  <= '0;
    end else if (!req_if.valid || req_if.ready) begin
      if (pending_words.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        req_if.valid <= 1'b1;
        req_if.data  <= pending_words.pop_front();
      end else begin
        req_if.valid <= 1'b0;
      end
    end
  end

  // Monitor: predicts from every accepted request word and checks every
  // accepted result word. Prediction goes first, though a result can never
  // share an edge with the run that causes it.
  always @(posedge clk_i or negedge rst_ni) begin
    res_word_t want;
    res_word_t got;
    if (!rst_ni) begin
      res_if.ready <= 1'b0;
    end else begin
      res_if.ready <= ($urandom_range(99) >= recv_stall_pct);
      if (req_if.valid && req_if.ready) begin
        apply_request(req_if.data);
        words_accepted++;
      end
      if (res_if.valid && res_if.ready) begin
        got = res_if.data;
        if (expected_services.size() == 0) begin
          $display("%0t: unexpected result word, expected none actual track %0d dist %0d",
                   $realtime, got.served_track, got.total_distance);
          mismatches++;
        end else begin
          want = expected_services.pop_front();
          compare_field("served_track", want.served_track, got.served_track);
          compare_field("total_distance", want.total_distance, got.total_distance);
          compare_field("served_index", want.served_index, got.served_index);
          compare_field("last_of_run", want.last_of_run, got.last_of_run);
          compare_field("empty_run", want.empty_run, got.empty_run);
          compare_field("overflow_seen", want.overflow_seen, got.overflow_seen);
        end
      end
    end
  end

  task automatic queue_word(input op_e op, input logic [TRACK_W-1:0] track);
    req_word_t w;
    w.op = op;
    w.track_value = track;
    pending_words = {pending_words, w};
    words_queued++;
  endtask

  // Draws a track in one of three styles: anywhere on the disk, inside a
  // narrow band just above a base so ties and repeats are common, or mostly at an edge.
  function automatic logic [TRACK_W-1:0] draw_track(input int unsigned style,
                                                    input logic [TRACK_W-1:0] base);
    case (style)
      0: begin
        return TRACK_W'($urandom_range(65535));
      end
      1: begin
        return base + TRACK_W'($urandom_range(15));
      end
      default: begin
        case ($urandom_range(2))
          0: return '0;
          1: return '1;
          default: return TRACK_W'($urandom_range(65535));
        endcase
      end
    endcase
  endfunction

  // Mostly load bursts closed by a run, sometimes an empty run, and where
  // allowed a burst that spills past the store so the dropped-load path runs.
  task automatic queue_random_batches(input int unsigned budget,
                                      input bit allow_overflow);
    int unsigned        spent;
    int unsigned        kind;
    int unsigned        loads;
    int unsigned        style;
    logic [TRACK_W-1:0] base;
    spent = 0;
    while (spent < budget) begin
      kind  = $urandom_range(99);
      style = $urandom_range(2);
      base  = TRACK_W'($urandom_range(65535));
      if (kind < 8) begin
        loads = 0;
      end else if (kind < 14 && allow_overflow) begin
        loads = $urandom_range(STORE_DEPTH + 4, STORE_DEPTH + 1);
      end else if (kind < 22) begin
        loads = $urandom_range(STORE_DEPTH, 9);
      end else begin
        loads = $urandom_range(8, 1);
      end
      for (int i = 0; i < loads; i++) begin
        queue_word(OP_LOAD, draw_track(style, base));
      end
      queue_word(OP_RUN, draw_track(style, base));
      spent += loads + 1;
    end
  endtask

  task automatic wait_words_sent;
    while (pending_words.size() != 0) @(negedge clk_i);
  endtask

  initial begin
    rst_ni = 1'b0;
    req_if.valid = 1'b0;
    req_if.data = '0;
    res_if.ready = 1'b0;
    words_queued = 0;
    words_accepted = 0;
    mismatches = 0;
    track_count = 0;
    overflow_latched = 1'b0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed words, full rate on both sides. Runs on an empty store come
    // first, while the overflow flag is still clear.
    queue_word(OP_RUN, 16'h0000);
    queue_word(OP_RUN, 16'hFFFF);
    // From 100, tracks 90 and 110 are equally near and the first pick takes
    // 110; from there 90 and 130 tie and the later pick takes 90.
    queue_word(OP_LOAD, 16'd90);
    queue_word(OP_LOAD, 16'd110);
    queue_word(OP_LOAD, 16'd130);
    queue_word(OP_RUN, 16'd100);
    // Repeated tracks are each served, at no added distance.
    queue_word(OP_LOAD, 16'd500);
    queue_word(OP_LOAD, 16'd500);
    queue_word(OP_RUN, 16'd500);
    // Both disk edges from the middle.
    queue_word(OP_LOAD, 16'hFFFF);
    queue_word(OP_LOAD, 16'h0000);
    queue_word(OP_RUN, 16'h8000);
    // Alternating bit patterns, and a far start toward one crowded edge.
    queue_word(OP_LOAD, 16'h5555);
    queue_word(OP_LOAD, 16'hAAAA);
    queue_word(OP_RUN, 16'hFFFF);
    queue_word(OP_LOAD, 16'hFFFF);
    queue_word(OP_LOAD, 16'hFFFF);
    queue_word(OP_LOAD, 16'hFFFF);
    queue_word(OP_RUN, 16'h0000);
    queue_random_batches(35, 1'b0);
    wait_words_sent();

    // Sender gaps.
    send_idle_pct = 68;
    recv_stall_pct = 0;
    queue_random_batches(45, 1'b0);
    wait_words_sent();

    // Receiver stalls.
    send_idle_pct = 0;
    recv_stall_pct = 68;
    queue_random_batches(45, 1'b0);
    wait_words_sent();

    // Light gaps on both sides; overflow is only provoked here, since the
    // flag stays set until reset. One full spill is always included.
    send_idle_pct = 18;
    recv_stall_pct = 18;
    queue_random_batches(30, 1'b1);
    for (int i = 0; i < STORE_DEPTH + 2; i++) begin
      queue_word(OP_LOAD, TRACK_W'($urandom_range(65535)));
    end
    queue_word(OP_RUN, TRACK_W'($urandom_range(65535)));
    queue_word(OP_RUN, TRACK_W'($urandom_range(65535)));
    wait_words_sent();

    while (words_accepted != words_queued || expected_services.size() != 0) begin
      @(negedge clk_i);
    end
    repeat (DRAIN_CYCLES) @(negedge clk_i);

    if (mismatches == 0 && expected_services.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  // Hard stop far beyond the slowest legal run.
  initial begin
    #20ms;
    $display("FAILURE");
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/sstf_pkg.sv
rtl/sstf_stream_if.sv
rtl/sstf_ctrl.sv
rtl/sstf_datapath.sv
rtl/sstf_disk_scheduler_core.sv
tb/tb_sstf_disk_scheduler_core.sv
